// ----- hdl/bpfa_pkg.sv -----
package bpfa_pkg;

    // fixed field widths
    localparam int unsigned ADDR_W      = 48;
    localparam int unsigned CNT_W       = 17;
    localparam int unsigned OPCODE_W    = 2;
    localparam int unsigned STATUS_W    = 2;

    // stream packing
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - (STATUS_W + ADDR_W + CNT_W);

    // page geometry
    localparam int unsigned PAGE_BYTES    = 4096;
    localparam int unsigned PAGE_SHIFT    = $clog2(PAGE_BYTES);
    // reserved pages = pages / 8 / PAGE_BYTES + 1
    localparam int unsigned RSV_SHIFT     = $clog2(8 * PAGE_BYTES);
    localparam int unsigned MAP_WORD_BITS = 64;
    localparam int unsigned BIT_W         = $clog2(MAP_WORD_BITS);

    typedef enum logic [OPCODE_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NO_PAGES     = 2'd1,
        STATUS_OUT_OF_RANGE = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        REG_REGION_START = 1'b0,
        REG_NUM_PAGES    = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_FREE_SUB,
        S_FREE_CHK,
        S_FREE_WR,
        S_FINISH
    } state_t;

endpackage

// ----- hdl/bpfa_ram.sv -----
module bpfa_ram #(
    parameter int unsigned WIDTH  = 64,
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/bitmap_page_frame_allocator.sv -----
// bitmap next-fit page frame allocator: one used/free bit per page, held in a
// single-port-write, registered-read map memory of MAP_WORD_BITS-bit words.
// each transaction on s_ gives exactly one result transaction on m_.
// per item: alloc reads and evaluates map words in turn, the scan starting at
// the word that holds the page after the last page handed out and wrapping
// once to word 0; free subtracts the region start, checks the range and
// writes the cleared bit, skipping the write when the address lies outside
// the region; init sweeps every map word once; no-op goes straight to the
// result. alloc and free work on the map by read-modify-write. after reset
// the map is cleared in a pass over all MAX_PAGES / MAP_WORD_BITS words
// (1024 by default) during which s_tready stays low; cfg writes are taken
// at any time. the result register lets the next transaction be accepted
// while a result waits on m_tready.
// region start and the number of pages are read live at each item; cfg writes
// must only happen while the block is idle.
module bitmap_page_frame_allocator #(
    parameter int unsigned MAX_PAGES = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // stream in
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] opcode, [49:2] free_address, [55:50] zero
    input  logic [bpfa_pkg::IN_TDATA_W-1:0]     s_tdata,
    // stream out
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [49:2] page_address, [66:50] used_pages, [71:67] zero
    output logic [bpfa_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0]         cfg_data
);

    import bpfa_pkg::*;

    localparam int unsigned MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int unsigned WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned IDX_W     = $clog2(MAX_PAGES);
    // wide enough for page counts, page indexes plus one and the used count
    localparam int unsigned CMP_W     = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam int unsigned FIDX_W    = ADDR_W - PAGE_SHIFT;
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

    // lowest clear bit of a map word
    function automatic logic [BIT_W-1:0] first_zero(input logic [MAP_WORD_BITS-1:0] v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int j = MAP_WORD_BITS - 1; j >= 0; j--)
        begin
            if (!v[j])
            begin
                pos = BIT_W'(j);
            end
        end
        return pos;
    endfunction

    // fsm and control
    state_t              state_reg;
    state_t              state_next;
    logic                out_valid_reg;
    logic                init_mode_reg;
    logic [WORD_W-1:0]   clr_word_reg;
    logic [WORD_W-1:0]   scan_word_reg;
    logic                wrap_reg;
    logic [CNT_W-1:0]    used_total_reg;
    logic [IDX_W-1:0]    last_given_reg;
    logic [ADDR_W-1:0]   region_start_reg;
    logic [CNT_W-1:0]    num_pages_reg;

    // item payload
    logic [ADDR_W-1:0]   free_addr_reg;
    logic [ADDR_W:0]     diff_reg;
    logic [WORD_W-1:0]   start_word_reg;
    logic [BIT_W-1:0]    start_bit_reg;
    logic [IDX_W-1:0]    found_reg;
    logic                give_addr_reg;
    status_t             status_reg;

    // result register
    status_t             out_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [CNT_W-1:0]    out_used_reg;

    // map memory port
    logic                     ram_we;
    logic [WORD_W-1:0]        ram_waddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic [WORD_W-1:0]        ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_rdata;

    opcode_t             in_op;
    logic                in_take;
    logic                out_free;

    logic [CMP_W-1:0]    pc_ext;
    logic [CMP_W-1:0]    pages;
    logic [CMP_W-1:0]    pages_m1;
    logic [CMP_W-1:0]    rsv;
    logic [CMP_W-1:0]    used_ext;
    logic [CMP_W-1:0]    start_full;
    logic [IDX_W-1:0]    start_idx;
    logic [WORD_W-1:0]   last_word;
    logic [BIT_W-1:0]    last_bit;
    logic                room;

    logic [MAP_WORD_BITS-1:0] low_mask;
    logic [MAP_WORD_BITS-1:0] high_mask;
    logic [MAP_WORD_BITS-1:0] busy;
    logic                     hit;
    logic [BIT_W-1:0]         hit_bit;
    logic [IDX_W-1:0]         hit_idx;
    logic                     scan_end;

    logic [FIDX_W-1:0]        free_page;
    logic                     free_in_range;
    logic [IDX_W-1:0]         free_idx;
    logic [WORD_W-1:0]        free_word;
    logic [BIT_W-1:0]         free_bit;

    logic [MAP_WORD_BITS-1:0] init_pattern;

    bpfa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS),
        .ADDR_W(WORD_W)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_op    = opcode_t'(s_tdata[OPCODE_W-1:0]);
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // effective page count: zero acts as one, clamp at MAX_PAGES
    assign pc_ext   = CMP_W'(num_pages_reg);
    assign pages    = (num_pages_reg == '0) ? CMP_W'(1) :
                      (pc_ext > CMP_W'(MAX_PAGES)) ? CMP_W'(MAX_PAGES) : pc_ext;
    assign pages_m1 = pages - CMP_W'(1);
    assign rsv      = (pages >> RSV_SHIFT) + CMP_W'(1);
    assign used_ext = CMP_W'(used_total_reg);
    assign room     = used_ext < pages;

    assign last_word = WORD_W'(pages_m1 >> BIT_W);
    assign last_bit  = pages_m1[BIT_W-1:0];

    // next-fit start, wrapping to page 0 when past the end
    assign start_full = CMP_W'(last_given_reg) + CMP_W'(1);
    assign start_idx  = (start_full >= pages) ? '0 : IDX_W'(start_full);

    // word evaluation: bits below the start (first pass) and past the end count as busy
    assign low_mask  = (!wrap_reg && scan_word_reg == start_word_reg) ?
                       ~({MAP_WORD_BITS{1'b1}} << start_bit_reg) : '0;
    assign high_mask = (scan_word_reg == last_word) ?
                       (({MAP_WORD_BITS{1'b1}} << last_bit) << 1) : '0;
    assign busy      = ram_rdata | low_mask | high_mask;
    assign hit       = ~&busy;
    assign hit_bit   = first_zero(busy);
    assign hit_idx   = IDX_W'({scan_word_reg, hit_bit});
    assign scan_end  = scan_word_reg == last_word;

    // free address decode
    assign free_page     = diff_reg[ADDR_W-1:PAGE_SHIFT];
    assign free_in_range = !diff_reg[ADDR_W] && (free_page < FIDX_W'(pages));
    assign free_idx      = IDX_W'(free_page);
    assign free_word     = WORD_W'(free_idx >> BIT_W);
    assign free_bit      = free_idx[BIT_W-1:0];

    // init sweep: reserved pages set, everything else clear; reset pass clears all
    always_comb
    begin
        for (int j = 0; j < MAP_WORD_BITS; j++)
        begin
            init_pattern[j] = init_mode_reg &&
                (((CMP_W'(clr_word_reg) << BIT_W) + CMP_W'(j)) < rsv);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_word_reg == LAST_WORD)
                begin
                    state_next = init_mode_reg ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_op)
                        OP_INIT:  state_next = S_CLEAR;
                        OP_ALLOC: state_next = room ? S_SCAN_RD : S_FINISH;
                        OP_FREE:  state_next = S_FREE_SUB;
                        default:  state_next = S_FINISH;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                if (hit || (scan_end && wrap_reg))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_FREE_SUB:
            begin
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                state_next = free_in_range ? S_FREE_WR : S_FINISH;
            end
            S_FREE_WR:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // fsm outputs: handshake and map port
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = scan_word_reg;
        ram_wdata = ram_rdata;
        ram_raddr = scan_word_reg;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_word_reg;
                ram_wdata = init_pattern;
            end
            S_SCAN_EV:
            begin
                ram_we    = hit;
                ram_wdata = ram_rdata | (MAP_WORD_BITS'(1) << hit_bit);
            end
            S_FREE_CHK:
            begin
                ram_raddr = free_word;
            end
            S_FREE_WR:
            begin
                ram_raddr = free_word;
                ram_we    = 1'b1;
                ram_waddr = free_word;
                ram_wdata = ram_rdata & ~(MAP_WORD_BITS'(1) << free_bit);
            end
            default:
            begin
                ram_raddr = scan_word_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            out_valid_reg    <= 1'b0;
            init_mode_reg    <= 1'b0;
            clr_word_reg     <= '0;
            scan_word_reg    <= '0;
            wrap_reg         <= 1'b0;
            used_total_reg   <= '0;
            last_given_reg   <= '0;
            region_start_reg <= '0;
            num_pages_reg    <= CNT_W'(1);
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_REGION_START: region_start_reg <= cfg_data;
                    REG_NUM_PAGES:    num_pages_reg    <= cfg_data[CNT_W-1:0];
                    default:          num_pages_reg    <= num_pages_reg;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        clr_word_reg  <= '0;
                        init_mode_reg <= 1'b1;
                        scan_word_reg <= WORD_W'(start_idx >> BIT_W);
                        wrap_reg      <= 1'b0;
                    end
                end
                S_CLEAR:
                begin
                    clr_word_reg <= clr_word_reg + WORD_W'(1);
                    if (clr_word_reg == LAST_WORD && init_mode_reg)
                    begin
                        used_total_reg <= CNT_W'(rsv);
                        last_given_reg <= IDX_W'(rsv - CMP_W'(1));
                    end
                end
                S_SCAN_EV:
                begin
                    if (hit)
                    begin
                        last_given_reg <= hit_idx;
                        used_total_reg <= used_total_reg + CNT_W'(1);
                    end
                    else if (scan_end)
                    begin
                        // second pass from page 0
                        wrap_reg      <= 1'b1;
                        scan_word_reg <= '0;
                    end
                    else
                    begin
                        scan_word_reg <= scan_word_reg + WORD_W'(1);
                    end
                end
                S_FREE_WR:
                begin
                    // count never drops below the reserved pages
                    if (used_ext > rsv)
                    begin
                        used_total_reg <= used_total_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    wrap_reg <= wrap_reg;
                end
            endcase

            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload and result register
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    free_addr_reg  <= s_tdata[OPCODE_W +: ADDR_W];
                    start_word_reg <= WORD_W'(start_idx >> BIT_W);
                    start_bit_reg  <= start_idx[BIT_W-1:0];
                    give_addr_reg  <= 1'b0;
                    status_reg     <= (in_op == OP_ALLOC && !room) ? STATUS_NO_PAGES
                                                                   : STATUS_OK;
                end
            end
            S_SCAN_EV:
            begin
                if (hit)
                begin
                    found_reg     <= hit_idx;
                    give_addr_reg <= 1'b1;
                end
                else if (scan_end && wrap_reg)
                begin
                    status_reg <= STATUS_NO_PAGES;
                end
            end
            S_FREE_SUB:
            begin
                diff_reg <= {1'b0, free_addr_reg} - {1'b0, region_start_reg};
            end
            S_FREE_CHK:
            begin
                if (!free_in_range)
                begin
                    status_reg <= STATUS_OUT_OF_RANGE;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_status_reg <= status_reg;
                    out_used_reg   <= used_total_reg;
                    out_addr_reg   <= give_addr_reg ?
                        region_start_reg + (ADDR_W'(found_reg) << PAGE_SHIFT) : '0;
                end
            end
            default:
            begin
                diff_reg <= diff_reg;
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{OUT_PAD_W{1'b0}}, out_used_reg, out_addr_reg, out_status_reg};

endmodule

// ----- tb/tb.sv -----
// self-checking bench for the bitmap page frame allocator
// a behavioral map of page bits runs beside the block and predicts every result
// at the moment its request transaction is accepted, and the checker compares each
// result transaction field by field against the oldest prediction
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    // map size of the instance, same as the block's default
    localparam int MAP_PAGES    = 65536;
    // random request transactions to send after the directed part
    localparam int RANDOM_ITEMS = 1000;
    // full-map alloc scans and inits are the slow items, and only a few hundred
    // items see either; this limit is several times the slowest correct run
    localparam int CYCLE_LIMIT  = 2_000_000;
    // quiet cycles after the last result, to catch a stray extra result
    localparam int SETTLE_CYCLES = 64;
    // mismatch lines printed before going quiet
    localparam int PRINT_LIMIT  = 40;

    // one expected or observed result, with the fields that m_tdata carries
    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   page_addr;
        logic [CNT_W-1:0]    used;
    } page_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    // [1:0] opcode, [49:2] free_address, [55:50] zero
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    // [1:0] status, [49:2] page_address, [66:50] used_pages, [71:67] zero
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic                    cfg_index;
    logic [ADDR_W-1:0]       cfg_data;

    // predicted block state, configuration as last written
    bit                      page_used [MAP_PAGES];
    int                      used_count;
    int                      last_page;
    logic [ADDR_W-1:0]       region_base;
    logic [CNT_W-1:0]        pages_cfg;

    // latest pages handed out since the last init (up to 256), to aim frees at used pages
    int                      granted_pages [$];
    // predictions waiting for their result transaction
    page_result_t            pending_results [$];

    int                      mismatch_count;
    int                      results_seen;
    int                      cycle_count;

    // sender burst shaping and receiver hold-off request
    bit                      sender_gaps;
    int                      burst_left;
    int                      hold_request;

    bitmap_page_frame_allocator #(
        .MAX_PAGES (MAP_PAGES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // page count as the block uses it: zero acts as one, big values clamp to the map
    function automatic int live_pages();
        int pages;
        if (pages_cfg == 0)
            pages = 1;
        else if (pages_cfg > MAP_PAGES)
            pages = MAP_PAGES;
        else
            pages = int'(pages_cfg);
        return pages;
    endfunction

    // applies one request to the predicted map and returns the result it gives
    function automatic page_result_t apply_page_op(opcode_t op, logic [ADDR_W-1:0] faddr);
        page_result_t res;
        int           pages;
        int           rsv;
        int           start;
        int           found;
        int           i;
        logic [63:0]  offset;
        logic [63:0]  addr;
        pages = live_pages();
        // pages that hold the map itself
        rsv = pages / (8 * PAGE_BYTES) + 1;
        res.status = STATUS_OK;
        res.page_addr = '0;
        case (op)
            OP_INIT:
            begin
                foreach (page_used[j])
                    page_used[j] = 1'b0;
                for (i = 0; i < rsv; i++)
                    page_used[i] = 1'b1;
                used_count = rsv;
                last_page = rsv - 1;
                granted_pages.delete();
            end
            OP_ALLOC:
            begin
                found = -1;
                if (used_count < pages)
                begin
                    // next fit: one past the last page given, start past the end wraps
                    start = last_page + 1;
                    if (start >= pages)
                        start = 0;
                    for (i = start; i < pages && found < 0; i++)
                        if (!page_used[i])
                            found = i;
                    for (i = 0; i < pages && found < 0; i++)
                        if (!page_used[i])
                            found = i;
                end
                if (found < 0)
                    res.status = STATUS_NO_PAGES;
                else
                begin
                    last_page = found;
                    page_used[found] = 1'b1;
                    used_count = (used_count + 1) & ((1 << CNT_W) - 1);
                    addr = {16'b0, region_base} + 64'(found) * 64'(PAGE_BYTES);
                    res.page_addr = addr[ADDR_W-1:0];
                    granted_pages.push_back(found);
                    if (granted_pages.size() > 256)
                        void'(granted_pages.pop_front());
                end
            end
            OP_FREE:
            begin
                if (faddr < region_base)
                    res.status = STATUS_OUT_OF_RANGE;
                else
                begin
                    offset = ({16'b0, faddr} - {16'b0, region_base}) / 64'(PAGE_BYTES);
                    if (offset >= 64'(pages))
                        res.status = STATUS_OUT_OF_RANGE;
                    else
                    begin
                        // cleared even when already free or reserved
                        page_used[int'(offset)] = 1'b0;
                        if (used_count > rsv)
                            used_count--;
                    end
                end
            end
            default:
            begin
                // no-op reports the count only
            end
        endcase
        res.used = used_count[CNT_W-1:0];
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[ADDR_W-1:0];
    endfunction

    // free target: mostly pages inside the region, some outside or fully random
    function automatic logic [ADDR_W-1:0] pick_free_addr();
        int                pages;
        int                idx;
        int                mode;
        logic [63:0]       addr;
        logic [ADDR_W-1:0] target;
        pages = live_pages();
        mode = $urandom_range(0, 9);
        if (mode < 7)
        begin
            if (mode == 6)
                idx = pages + $urandom_range(0, 3);
            else if (granted_pages.size() != 0 && $urandom_range(0, 2) != 0)
                idx = granted_pages[$urandom_range(0, granted_pages.size() - 1)];
            else
                idx = $urandom_range(0, pages - 1);
            addr = {16'b0, region_base} + 64'(idx) * 64'(PAGE_BYTES);
            // unaligned now and then, inside the same page
            if ($urandom_range(0, 3) == 0)
                addr = addr + 64'($urandom_range(0, PAGE_BYTES - 1));
            target = addr[ADDR_W-1:0];
        end
        else if (mode == 7)
            target = region_base - ADDR_W'($urandom_range(1, 2 * PAGE_BYTES));
        else
            target = rand_addr();
        return target;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
    endtask

    // one request transaction; the prediction is made at the accepting edge
    task automatic send_item(opcode_t op, logic [ADDR_W-1:0] addr);
        page_result_t want;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {{(IN_TDATA_W - OPCODE_W - ADDR_W){1'b0}}, addr, op};
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        want = apply_page_op(op, addr);
        pending_results.push_back(want);
        // end of a burst: drop valid for a random gap
        if (sender_gaps && burst_left == 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 7))
                @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        else if (burst_left > 0)
            burst_left--;
    endtask

    // register write transaction, only issued while the block is idle
    task automatic cfg_write(cfg_reg_t idx, logic [ADDR_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        if (idx == REG_REGION_START)
            region_base = data;
        else
            pages_cfg = data[CNT_W-1:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // sender pauses until every predicted result has come back
    task automatic wait_results_done();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // reset map: alloc, full count, frees on a one-page region, no-op
    task automatic test_use_before_init();
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '1);
        // unaligned free of page 0, count held at the reserved floor
        send_item(OP_FREE, 48'h0000_0000_0FFF);
        send_item(OP_FREE, 48'h0000_0000_1000);
        send_item(OP_NOP, rand_addr());
        // count still full though the bit is clear
        send_item(OP_ALLOC, '0);
    endtask

    // five-page region: fill, run out, free, wrap, out-of-range, saturation
    task automatic test_next_fit_and_wrap();
        logic [ADDR_W-1:0] base;
        int                k;
        base = 48'h0000_1234_5000;
        wait_results_done();
        cfg_write(REG_REGION_START, base);
        cfg_write(REG_NUM_PAGES, 48'd5);
        send_item(OP_INIT, '0);
        for (k = 0; k < 5; k++)
            send_item(OP_ALLOC, '0);
        send_item(OP_FREE, base + 48'h2123);
        // page already free
        send_item(OP_FREE, base + 48'h2000);
        // search starts past the end and wraps to the freed page
        send_item(OP_ALLOC, '0);
        send_item(OP_FREE, base - 48'd1);
        send_item(OP_FREE, base + 48'h5000);
        // reserved page, then down to the reserved floor and one more
        send_item(OP_FREE, base);
        send_item(OP_FREE, base + 48'h1000);
        send_item(OP_FREE, base + 48'h3000);
        send_item(OP_FREE, base + 48'h4000);
        // shrink the region under a search start beyond its end
        wait_results_done();
        cfg_write(REG_NUM_PAGES, 48'd3);
        send_item(OP_ALLOC, '0);
    endtask

    // top of the address space, clamped and zero page counts
    task automatic test_size_extremes();
        wait_results_done();
        cfg_write(REG_REGION_START, 48'hFFFF_FFFF_F000);
        cfg_write(REG_NUM_PAGES, 48'h1_FFFF);
        send_item(OP_INIT, '0);
        // page address wraps past the top of the 48-bit space
        send_item(OP_ALLOC, '1);
        send_item(OP_FREE, 48'hFFFF_FFFF_FFFF);
        send_item(OP_FREE, 48'h0000_0000_2000);
        wait_results_done();
        cfg_write(REG_NUM_PAGES, 48'd0);
        send_item(OP_ALLOC, '0);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_hold_off();
        int k;
        wait_results_done();
        cfg_write(REG_REGION_START, 48'h0000_8000_0000);
        cfg_write(REG_NUM_PAGES, 48'd24);
        send_item(OP_INIT, '0);
        sender_gaps = 1'b0;
        hold_request = 400;
        for (k = 0; k < 24; k++)
        begin
            if (k % 3 == 2)
                send_item(OP_FREE, pick_free_addr());
            else
                send_item(OP_ALLOC, rand_addr());
        end
        sender_gaps = 1'b1;
        wait_results_done();
    endtask

    // random phases: fresh registers, usually an init, then a random request mix
    task automatic test_random_phases();
        int                sent;
        int                phase_len;
        int                k;
        int                pick;
        opcode_t           op;
        logic [ADDR_W-1:0] base;
        logic [CNT_W-1:0]  pc;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_results_done();
            case ($urandom_range(0, 5))
                0:       base = '0;
                1:       base = 48'hFFFF_FFFF_F000;
                2:       base = rand_addr();
                3:       base = 48'(64'($urandom_range(0, 4096)) * 64'(PAGE_BYTES));
                default: base = rand_addr() & ~ADDR_W'(PAGE_BYTES - 1);
            endcase
            case ($urandom_range(0, 9))
                0:       pc = '0;
                1:       pc = 17'd1;
                2:       pc = 17'd2;
                6:       pc = 17'($urandom_range(25, 200));
                7:       pc = 17'((64 << $urandom_range(0, 2)) + $urandom_range(0, 2) - 1);
                8:
                begin
                    case ($urandom_range(0, 5))
                        0:       pc = 17'd32767;
                        1:       pc = 17'd32768;
                        2:       pc = 17'd65536;
                        3:       pc = '1;
                        4:       pc = 17'($urandom_range(65537, 131071));
                        default: pc = 17'($urandom_range(1024, 65536));
                    endcase
                end
                default: pc = 17'($urandom_range(3, 24));
            endcase
            cfg_write(REG_REGION_START, base);
            cfg_write(REG_NUM_PAGES, {{(ADDR_W - CNT_W){1'b0}}, pc});
            sender_gaps = ($urandom_range(0, 3) != 0);
            // big maps make inits and wrapped scans slow, so keep those phases short
            phase_len = (live_pages() > 1024) ? 20 : $urandom_range(30, 80);
            if ($urandom_range(0, 9) != 0)
            begin
                send_item(OP_INIT, rand_addr());
                sent++;
            end
            for (k = 0; k < phase_len; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    op = OP_ALLOC;
                else if (pick < 86)
                    op = OP_FREE;
                else if (pick < 93)
                    op = OP_INIT;
                else
                    op = OP_NOP;
                if (op == OP_FREE)
                    send_item(op, pick_free_addr());
                else
                    send_item(op, rand_addr());
                sent++;
            end
        end
        sender_gaps = 1'b1;
    endtask

    // result side: ready pattern changes every so often, hold-off on request
    initial
    begin : result_receiver
        logic [15:0] ready_pattern;
        int          pattern_left;
        int          hold_left;
        int          bit_pos;
        m_tready = 1'b0;
        ready_pattern = '1;
        pattern_left = 0;
        hold_left = 0;
        bit_pos = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       ready_pattern = '1;
                        1:       ready_pattern = 16'($urandom()) | 16'h0001;
                        2:       ready_pattern = ~(16'h0001 << $urandom_range(0, 15));
                        default: ready_pattern = 16'h5555;
                    endcase
                    pattern_left = $urandom_range(16, 128);
                end
                m_tready = ready_pattern[bit_pos];
                bit_pos = (bit_pos + 1) % 16;
                pattern_left--;
            end
        end
    end

    // compares each accepted result transaction with the oldest prediction
    initial
    begin : result_checker
        page_result_t want;
        page_result_t got;
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                results_seen++;
                got.status    = status_t'(m_tdata[STATUS_W-1:0]);
                got.page_addr = m_tdata[STATUS_W +: ADDR_W];
                got.used      = m_tdata[STATUS_W + ADDR_W +: CNT_W];
                if (pending_results.size() == 0)
                    report_mismatch("result with no request waiting for it");
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.page_addr !== want.page_addr)
                        report_mismatch($sformatf("page_address 0x%0h, expected 0x%0h",
                                                  got.page_addr, want.page_addr));
                    if (got.used !== want.used)
                        report_mismatch($sformatf("used_pages %0d, expected %0d",
                                                  got.used, want.used));
                end
            end
        end
    end

    // watchdog on a cycle count
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bitmap_page_frame_allocator: mismatch");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_REGION_START;
        cfg_data = '0;
        // predicted state after reset: empty map, base 0, one page
        region_base = '0;
        pages_cfg = 17'd1;
        used_count = 0;
        last_page = 0;
        mismatch_count = 0;
        results_seen = 0;
        sender_gaps = 1'b1;
        burst_left = 0;
        hold_request = 0;
        repeat (8)
            @(negedge clk);
        rst_n = 1'b1;

        test_use_before_init();
        test_next_fit_and_wrap();
        test_size_extremes();
        test_output_hold_off();
        test_random_phases();

        wait_results_done();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("bitmap_page_frame_allocator: match");
        else
            $display("bitmap_page_frame_allocator: mismatch");
        $finish;
    end

endmodule
